@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion forms, sampled on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tkl_pkg.sv @@
// ----------------------------------------------------------------------------
// tkl_pkg
// Types, codes and key expansion tables for the keyboard line discipline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkl_pkg;

  // default line store size
  localparam int LINE_CAPACITY_DEF = 32;

  // byte queue between front and back
  localparam int QUEUE_DEPTH = 8;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_CANONICAL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_ERASE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_KILL  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ERASE_CHAR = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KILL_CHAR  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_EOF_CHAR   = 3'd6;

  // register reset values
  localparam logic [7:0] ERASE_CHAR_RST = 8'd127;
  localparam logic [7:0] KILL_CHAR_RST  = 8'd21;
  localparam logic [7:0] EOF_CHAR_RST   = 8'd4;

  // result kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_EOF   = 2'd3;

  // key codes
  localparam logic [7:0] KEY_NULL      = 8'd0;
  localparam logic [7:0] KEY_ASCII_MAX = 8'd127;
  localparam logic [7:0] KEY_RETURN    = 8'd128;
  localparam logic [7:0] KEY_RUBOUT    = 8'd129;
  localparam logic [7:0] KEY_INTR      = 8'd130;
  localparam logic [7:0] KEY_SUSP      = 8'd131;
  localparam logic [7:0] KEY_CTRL_BSL  = 8'd132;
  localparam logic [7:0] KEY_ESC_FIRST = 8'd133;
  localparam logic [7:0] KEY_ESC_LAST  = 8'd153;

  // byte values
  localparam logic [7:0] ASCII_ETX = 8'h03;
  localparam logic [7:0] ASCII_SUB = 8'h1A;
  localparam logic [7:0] ASCII_FS  = 8'h1C;
  localparam logic [7:0] ASCII_LF  = 8'h0A;
  localparam logic [7:0] ASCII_CR  = 8'h0D;

  typedef struct packed {
    logic       canonical_mode;
    logic       echo_on;
    logic       echo_erase_on;
    logic       echo_kill_on;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] eof_char;
  } cfg_t;

  // one byte on its way from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_entry_t;

  // escape text of the navigation and function keys, first byte on top
  function automatic logic [39:0] esc_word(input logic [4:0] e);
    logic [39:0] w;
    case (e)
      5'd0:    w = 40'h1B5B410000;  // up
      5'd1:    w = 40'h1B5B420000;  // down
      5'd2:    w = 40'h1B5B430000;  // right
      5'd3:    w = 40'h1B5B440000;  // left
      5'd4:    w = 40'h1B5B480000;  // home
      5'd5:    w = 40'h1B5B460000;  // end
      5'd6:    w = 40'h1B5B357E00;  // pgup
      5'd7:    w = 40'h1B5B367E00;  // pgdn
      5'd8:    w = 40'h1B5B337E00;  // delete
      5'd9:    w = 40'h1B4F500000;  // F1
      5'd10:   w = 40'h1B4F510000;
      5'd11:   w = 40'h1B4F520000;
      5'd12:   w = 40'h1B4F530000;  // F4
      5'd13:   w = 40'h1B5B31357E;  // F5
      5'd14:   w = 40'h1B5B31377E;
      5'd15:   w = 40'h1B5B31387E;
      5'd16:   w = 40'h1B5B31397E;
      5'd17:   w = 40'h1B5B32307E;
      5'd18:   w = 40'h1B5B32317E;
      5'd19:   w = 40'h1B5B32337E;
      5'd20:   w = 40'h1B5B32347E;  // F12
      default: w = 40'h0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] esc_len(input logic [4:0] e);
    logic [2:0] n;
    if (e <= 5'd5)       n = 3'd3;
    else if (e <= 5'd8)  n = 3'd4;
    else if (e <= 5'd12) n = 3'd3;
    else if (e <= 5'd20) n = 3'd5;
    else                 n = 3'd0;
    return n;
  endfunction

  // number of bytes a key expands to
  function automatic logic [2:0] key_len(input logic [7:0] k);
    logic [2:0] n;
    logic [4:0] e;
    e = 5'(k - KEY_ESC_FIRST);
    if (k == KEY_NULL)           n = 3'd0;
    else if (k <= KEY_CTRL_BSL)  n = 3'd1;
    else if (k <= KEY_ESC_LAST)  n = esc_len(e);
    else                         n = 3'd0;
    return n;
  endfunction

  // byte at position pos of the expansion of key k
  function automatic logic [7:0] key_byte(input logic [7:0] k, input logic [2:0] pos,
                                          input logic [7:0] erase);
    logic [39:0] w;
    logic [7:0]  b;
    w = esc_word(5'(k - KEY_ESC_FIRST));
    if (k <= KEY_ASCII_MAX)       b = k;
    else if (k == KEY_RETURN)     b = ASCII_CR;
    else if (k == KEY_RUBOUT)     b = erase;
    else if (k == KEY_INTR)       b = ASCII_ETX;
    else if (k == KEY_SUSP)       b = ASCII_SUB;
    else if (k == KEY_CTRL_BSL)   b = ASCII_FS;
    else begin
      case (pos)
        3'd0:    b = w[39:32];
        3'd1:    b = w[31:24];
        3'd2:    b = w[23:16];
        3'd3:    b = w[15:8];
        default: b = w[7:0];
      endcase
    end
    return b;
  endfunction

endpackage

@@ hdl/tty_keyboard_line_discipline.sv @@
// ----------------------------------------------------------------------------
// tty_keyboard_line_discipline
// Keyboard to terminal byte stream with raw and canonical line editing.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / key): one key code per request. The
// key is expanded into 0 to 5 bytes (ASCII, CR, control bytes, escape text)
// at one byte per cycle, while the queue is not full, into an 8-entry byte
// queue; in_stall is high while a key's bytes are being queued.
// Output channel (out_valid / out_stall / kind, value, line_end, last): one
// result per request, last set on the final result caused by a key.
// The line editor takes each byte through a queue pop, then an edit, with a
// further step for raw data and one to close each key; a kill erases one
// character a cycle, pausing while the output is held, and a line is
// delivered by reading each byte from the line store, then emitting it.
// When out_stall is high the output register holds; one further result waits
// in a hold register and the editor pauses, while keys keep filling the queue.
// Reset (rst, synchronous) empties queue and line, and loads register
// defaults: canonical mode, all echo on, erase 127, kill 21, eof 4.
// Configuration: cfg_write with cfg_index and cfg_data, only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tty_keyboard_line_discipline import tkl_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             key,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             value,
  output logic                   line_end,
  output logic                   last
);

  cfg_t        cfg;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;
  byte_entry_t q_in;
  byte_entry_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canonical_mode <= 1'b1;
      cfg.echo_on        <= 1'b1;
      cfg.echo_erase_on  <= 1'b1;
      cfg.echo_kill_on   <= 1'b1;
      cfg.erase_char     <= ERASE_CHAR_RST;
      cfg.kill_char      <= KILL_CHAR_RST;
      cfg.eof_char       <= EOF_CHAR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CANONICAL:  cfg.canonical_mode <= cfg_data[0];
        REG_ECHO:       cfg.echo_on        <= cfg_data[0];
        REG_ECHO_ERASE: cfg.echo_erase_on  <= cfg_data[0];
        REG_ECHO_KILL:  cfg.echo_kill_on   <= cfg_data[0];
        REG_ERASE_CHAR: cfg.erase_char     <= cfg_data;
        REG_KILL_CHAR:  cfg.kill_char      <= cfg_data;
        REG_EOF_CHAR:   cfg.eof_char       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tkl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .key      (key),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  tkl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  tkl_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .line_end  (line_end),
    .last      (last)
  );

endmodule

@@ hdl/tkl_queue.sv @@
// ----------------------------------------------------------------------------
// tkl_queue
// Small byte FIFO that decouples key expansion from line editing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkl_queue import tkl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  byte_entry_t push_entry,
  input  logic        pop,
  output byte_entry_t head,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  byte_entry_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        count;
  logic                    do_push;
  logic                    do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (do_pop)  rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      if (do_push && !do_pop)      count <= CNT_W'(count + 1'b1);
      else if (do_pop && !do_push) count <= CNT_W'(count - 1'b1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_entry;
  end

endmodule

@@ hdl/tkl_front.sv @@
// ----------------------------------------------------------------------------
// tkl_front
// Accepts key requests and expands each key into its byte sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkl_front import tkl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key,
  input  logic        q_full,
  output logic        q_push,
  output byte_entry_t q_entry
);

  logic       busy;
  logic [7:0] key_r;
  logic [2:0] pos;
  logic [2:0] nb;
  logic [2:0] key_nb;
  logic       accept;
  logic       final_byte;

  assign key_nb     = key_len(key);
  assign in_stall   = busy;
  assign accept     = in_valid && !busy;
  assign final_byte = (3'(pos + 3'd1) == nb);

  // one byte per cycle into the queue, while the queue is not full
  assign q_push        = busy && !q_full;
  assign q_entry.data  = key_byte(key_r, pos, cfg.erase_char);
  assign q_entry.last  = final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= (key_nb != 3'd0);
    end else if (q_push && final_byte) begin
      busy <= 1'b0;
    end
  end

  // held key and byte position
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= key;
      nb    <= key_nb;
      pos   <= 3'd0;
    end else if (q_push) begin
      pos   <= 3'(pos + 3'd1);
    end
  end

endmodule

@@ hdl/tkl_back.sv @@
// ----------------------------------------------------------------------------
// tkl_back
// Line editor: applies raw or canonical rules to each byte and emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkl_back import tkl_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  byte_entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic        line_end,
  output logic        last
);

  localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0]  CAP      = LEN_W'(LINE_CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(LINE_CAPACITY - 1);

  localparam logic [2:0] S_FETCH    = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_RAW_DATA = 3'd2;
  localparam logic [2:0] S_KILL     = 3'd3;
  localparam logic [2:0] S_DLV_RD   = 3'd4;
  localparam logic [2:0] S_DLV_OUT  = 3'd5;
  localparam logic [2:0] S_CLOSE    = 3'd6;

  logic [2:0]        state, state_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic [7:0]        cur_byte;
  logic              cur_last;

  // line store
  logic [7:0]        mem [LINE_CAPACITY];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // result generated this cycle
  logic              gen;
  logic [1:0]        g_kind;
  logic [7:0]        g_value;
  logic              g_le;
  logic              close;

  // one result held back until it is known whether it ends the request
  logic              hold_valid;
  logic              hold_closed;
  logic [1:0]        hold_kind;
  logic [7:0]        hold_value;
  logic              hold_le;

  logic              out_free;
  logic              room;
  logic              move;

  logic              erase_echo;
  logic              kill_echo;
  logic              is_eof, is_nl, is_erase, is_kill;
  logic              len_zero, len_full, dlv_end;
  logic [2:0]        after_byte;

  assign out_free   = !out_valid || !out_stall;
  assign room       = !hold_valid || out_free;
  assign move       = hold_valid && out_free && (hold_closed || gen);

  assign erase_echo = cfg.echo_on || cfg.echo_erase_on;
  assign kill_echo  = cfg.echo_on && cfg.echo_kill_on;
  assign is_eof     = (cur_byte == cfg.eof_char);
  assign is_nl      = (cur_byte == ASCII_LF) || (cur_byte == ASCII_CR);
  assign is_erase   = (cur_byte == cfg.erase_char);
  assign is_kill    = (cur_byte == cfg.kill_char);
  assign len_zero   = (len == '0);
  assign len_full   = (len == CAP);
  assign dlv_end    = (LEN_W'(idx + 1'b1) == len);
  assign after_byte = cur_last ? S_CLOSE : S_FETCH;

  // byte sequencer
  always_comb begin
    state_next = state;
    len_next   = len;
    idx_next   = idx;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = len[ADDR_W-1:0];
    wr_data    = cur_byte;
    gen        = 1'b0;
    g_kind     = KIND_ECHO;
    g_value    = 8'd0;
    g_le       = 1'b0;
    close      = 1'b0;
    case (state)
      S_FETCH: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!cfg.canonical_mode) begin
          // raw: optional echo, then the data byte
          if (!cfg.echo_on) begin
            state_next = S_RAW_DATA;
          end else if (room) begin
            gen        = 1'b1;
            g_value    = cur_byte;
            state_next = S_RAW_DATA;
          end
        end else if (is_eof) begin
          if (!len_zero) begin
            idx_next   = '0;
            state_next = S_DLV_RD;
          end else if (room) begin
            gen        = 1'b1;
            g_kind     = KIND_EOF;
            state_next = after_byte;
          end
        end else if (is_nl) begin
          // store LF (over the last byte on a full line), then deliver
          if (room || !cfg.echo_on) begin
            gen        = cfg.echo_on;
            g_value    = ASCII_LF;
            wr_en      = 1'b1;
            wr_addr    = len_full ? LAST_ADR : len[ADDR_W-1:0];
            wr_data    = ASCII_LF;
            len_next   = len_full ? len : LEN_W'(len + 1'b1);
            idx_next   = '0;
            state_next = S_DLV_RD;
          end
        end else if (is_erase) begin
          if (len_zero) begin
            state_next = after_byte;
          end else if (room || !erase_echo) begin
            gen        = erase_echo;
            g_kind     = KIND_ERASE;
            len_next   = LEN_W'(len - 1'b1);
            state_next = after_byte;
          end
        end else if (is_kill) begin
          state_next = S_KILL;
        end else begin
          // ordinary byte, dropped on a full line
          if (len_full) begin
            state_next = after_byte;
          end else if (room || !cfg.echo_on) begin
            gen        = cfg.echo_on;
            g_value    = cur_byte;
            wr_en      = 1'b1;
            len_next   = LEN_W'(len + 1'b1);
            state_next = after_byte;
          end
        end
      end
      S_RAW_DATA: begin
        if (room) begin
          gen        = 1'b1;
          g_kind     = KIND_DATA;
          g_value    = cur_byte;
          state_next = after_byte;
        end
      end
      S_KILL: begin
        // erase one character a cycle (waiting for room when echoed), then the optional newline
        if (!len_zero) begin
          if (room || !erase_echo) begin
            gen      = erase_echo;
            g_kind   = KIND_ERASE;
            len_next = LEN_W'(len - 1'b1);
          end
        end else if (!kill_echo) begin
          state_next = after_byte;
        end else if (room) begin
          gen        = 1'b1;
          g_value    = ASCII_LF;
          state_next = after_byte;
        end
      end
      S_DLV_RD: begin
        rd_en      = 1'b1;
        state_next = S_DLV_OUT;
      end
      S_DLV_OUT: begin
        if (room) begin
          gen     = 1'b1;
          g_kind  = KIND_DATA;
          g_value = rd_data;
          g_le    = dlv_end;
          if (dlv_end) begin
            len_next   = '0;
            state_next = after_byte;
          end else begin
            idx_next   = LEN_W'(idx + 1'b1);
            state_next = S_DLV_RD;
          end
        end
      end
      S_CLOSE: begin
        close      = 1'b1;
        state_next = S_FETCH;
      end
      default: begin
        state_next = S_FETCH;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FETCH;
      len         <= '0;
      hold_valid  <= 1'b0;
      hold_closed <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (move)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (gen) begin
        hold_valid  <= 1'b1;
        hold_closed <= 1'b0;
      end else begin
        if (move)  hold_valid  <= 1'b0;
        if (close) hold_closed <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (q_pop) begin
      cur_byte <= q_head.data;
      cur_last <= q_head.last;
    end
    if (gen) begin
      hold_kind  <= g_kind;
      hold_value <= g_value;
      hold_le    <= g_le;
    end
    if (move) begin
      kind     <= hold_kind;
      value    <= hold_value;
      line_end <= hold_le;
      last     <= hold_closed;
    end
  end

  // line store memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[idx[ADDR_W-1:0]];
  end

endmodule

@@ hdl/tkl_checker.sv @@
// ----------------------------------------------------------------------------
// tkl_checker
// Port-level checks of the keyboard line discipline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tkl_checker import tkl_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] key,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] value,
  input logic       line_end,
  input logic       last
);

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(kind) && $stable(value) && $stable(line_end) && $stable(last),
    "stalled result changed")

  // erase triples and end of file carry no byte
  `ASSERT_IMPLIES(a_zero_value, out_valid && (kind == KIND_ERASE || kind == KIND_EOF),
    value == 8'd0, "nonzero value on erase or eof result")

  // only delivered data can close a line
  `ASSERT_ALWAYS(a_line_end_data, !(out_valid && line_end) || kind == KIND_DATA,
    "line_end on a result that is not data")

  // a mapped key keeps the front busy the cycle after it is taken
  `ASSERT_NEXT(a_key_busy,
    in_valid && !in_stall && key != KEY_NULL && key <= KEY_ESC_LAST,
    in_stall, "mapped key did not occupy the front")

endmodule

bind tty_keyboard_line_discipline tkl_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .key       (key),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .value     (value),
  .line_end  (line_end),
  .last      (last)
);
